// ===== sv/kws_pkg.sv =====
`timescale 1ns / 1ps

package kws_pkg;

   // window and keyword table geometry
   localparam int WINDOW_BYTES = 19;
   localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);
   localparam int KW_LEN_W     = $clog2(WINDOW_BYTES + 1);
   localparam int KW_COUNT     = 12;
   localparam int GROUP_COUNT  = 6;
   localparam int GROUP_W      = $clog2(GROUP_COUNT);

   // image counters and registers
   localparam int COUNT_W      = 14;
   localparam int MIN_SIZE_W   = 8;
   localparam int CSR_DATA_W   = 14;
   localparam int CSR_INDEX_W  = 2;
   localparam int VERDICT_W    = 3;

   localparam logic [COUNT_W-1:0]    COUNT_MAX       = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0]    SCAN_LIMIT_RST  = COUNT_W'(8192);
   localparam logic [MIN_SIZE_W-1:0] MIN_SIZE_RST    = MIN_SIZE_W'(64);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCAN_LIMIT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SIZE   = CSR_INDEX_W'(1);

   // verdict codes; a flagged group g reports g + 1
   localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = VERDICT_W'(0);

   // header signature bytes
   localparam logic [7:0] HDR_BYTE0 = 8'h4D;
   localparam logic [7:0] HDR_BYTE1 = 8'h5A;

   typedef logic [7:0] byte_type;
   typedef byte_type kw_row_type [WINDOW_BYTES];
   typedef logic [KW_COUNT-1:0] kw_hits_type;

   // keyword text, newest byte first: entry i must sit in window cell i
   localparam kw_row_type KW_REV [KW_COUNT] = '{
      '{0:8'h6C, 1:8'h65, 2:8'h74, 3:8'h6E, 4:8'h49, default:8'h00},
      '{0:8'h4C, 1:8'h45, 2:8'h54, 3:8'h4E, 4:8'h49, default:8'h00},
      '{0:8'h49, 1:8'h4D, 2:8'h41, default:8'h00},
      '{0:8'h73, 1:8'h64, 2:8'h6E, 3:8'h65, 4:8'h72, 5:8'h74, 6:8'h61, 7:8'h67,
        8:8'h65, 9:8'h4D, 10:8'h20, 11:8'h6E, 12:8'h61, 13:8'h63, 14:8'h69,
        15:8'h72, 16:8'h65, 17:8'h6D, 18:8'h41, default:8'h00},
      '{0:8'h74, 1:8'h66, 2:8'h6F, 3:8'h73, 4:8'h6F, 5:8'h72, 6:8'h63, 7:8'h69,
        8:8'h4D, default:8'h00},
      '{0:8'h54, 1:8'h46, 2:8'h53, 3:8'h4D, default:8'h00},
      '{0:8'h78, 1:8'h69, 2:8'h6E, 3:8'h65, 4:8'h6F, 5:8'h68, 6:8'h50, default:8'h00},
      '{0:8'h65, 1:8'h64, 2:8'h79, 3:8'h73, 4:8'h6E, 5:8'h49, default:8'h00},
      '{0:8'h74, 1:8'h68, 2:8'h67, 3:8'h69, 4:8'h72, 5:8'h79, 6:8'h70, 7:8'h6F,
        8:8'h43, default:8'h00},
      '{0:8'h79, 1:8'h72, 2:8'h61, 3:8'h74, 4:8'h65, 5:8'h69, 6:8'h72, 7:8'h70,
        8:8'h6F, 9:8'h72, 10:8'h50, default:8'h00},
      '{0:8'h65, 1:8'h73, 2:8'h6E, 3:8'h65, 4:8'h63, 5:8'h69, 6:8'h4C, default:8'h00},
      '{0:8'h64, 1:8'h65, 2:8'h76, 3:8'h72, 4:8'h65, 5:8'h73, 6:8'h65, 7:8'h72,
        8:8'h20, 9:8'h73, 10:8'h74, 11:8'h68, 12:8'h67, 13:8'h69, 14:8'h72,
        15:8'h20, 16:8'h6C, 17:8'h6C, 18:8'h41, default:8'h00}
   };

   localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
      KW_LEN_W'(5), KW_LEN_W'(5), KW_LEN_W'(3), KW_LEN_W'(19), KW_LEN_W'(9),
      KW_LEN_W'(4), KW_LEN_W'(7), KW_LEN_W'(6), KW_LEN_W'(9), KW_LEN_W'(11),
      KW_LEN_W'(7), KW_LEN_W'(19)
   };

   localparam logic [GROUP_W-1:0] KW_GROUP [KW_COUNT] = '{
      GROUP_W'(0), GROUP_W'(0), GROUP_W'(1), GROUP_W'(1), GROUP_W'(2),
      GROUP_W'(2), GROUP_W'(3), GROUP_W'(4), GROUP_W'(5), GROUP_W'(5),
      GROUP_W'(5), GROUP_W'(5)
   };

   // per-byte summary handed from the image bookkeeping to the matcher
   typedef struct packed {
      logic valid;
      logic last;
      logic scan;
      logic size_ok;
      logic header;
   } kws_step_type;

endpackage

// ===== sv/keyword_signature_classifier.sv =====
`timescale 1ns / 1ps
// A verdict passes the step register, then the output register, before showing on rsp_.
// Throughput: one byte per cycle while req_stall is low; the window cells shift and the
// compares of the previous byte run in the same cycle, so images may follow back to back.
// req_stall rises only while a verdict waits behind a stalled one in the output register.
// Reset (synchronous, active high) clears the window, counters, flags and output valid,
// and sets scan_limit to 8192 and min_size to 64.

module keyword_signature_classifier
   import kws_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VERDICT_W-1:0]   rsp_verdict,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [COUNT_W-1:0]    scan_limit_ff;
   logic [COUNT_W-1:0]    scan_limit_in;
   logic [MIN_SIZE_W-1:0] min_size_ff;
   logic [MIN_SIZE_W-1:0] min_size_in;
   logic [COUNT_W-1:0]    byte_count_ff;
   logic [COUNT_W-1:0]    byte_count_in;
   logic                  header_ff;
   logic                  header_in;
   logic                  fresh_ff;
   logic                  fresh_in;
   logic                  accept;
   logic                  hold;
   logic                  header_now;
   kws_step_type          step;
   logic [7:0]            cell_din  [WINDOW_BYTES];
   logic [7:0]            cell_dout [WINDOW_BYTES];
   kw_hits_type           cell_hits [WINDOW_BYTES];

   assign req_stall = hold;
   assign accept    = req_valid && !req_stall;

   // register writes
   always_comb begin
      scan_limit_in = scan_limit_ff;
      min_size_in   = min_size_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SCAN_LIMIT: scan_limit_in = csr_wdata;
            CSR_MIN_SIZE:   min_size_in   = csr_wdata[MIN_SIZE_W-1:0];
            default:        ;
         endcase
      end
   end

   // the row of window cells; the first byte of an image enters an empty row
   always_comb begin
      cell_din[0] = req_data_byte;
      for (int i = 1; i < WINDOW_BYTES; i++) begin
         cell_din[i] = fresh_ff ? 8'h00 : cell_dout[i-1];
      end
   end

   for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
      kws_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (accept),
         .din   (cell_din[i]),
         .pos   (WIN_IDX_W'(i)),
         .dout  (cell_dout[i]),
         .hits  (cell_hits[i])
      );
   end

   // per-byte image bookkeeping
   assign header_now = header_ff || ((byte_count_ff == COUNT_W'(1)) &&
                       (cell_dout[0] == HDR_BYTE0) && (req_data_byte == HDR_BYTE1));

   always_comb begin
      step.valid   = accept;
      step.last    = req_last_byte;
      step.scan    = byte_count_ff < scan_limit_ff;
      step.size_ok = ((COUNT_W + 1)'(byte_count_ff) + (COUNT_W + 1)'(1)) >=
                     (COUNT_W + 1)'(min_size_ff);
      step.header  = header_now;

      byte_count_in = byte_count_ff;
      header_in     = header_ff;
      fresh_in      = fresh_ff;
      if (accept) begin
         if (req_last_byte) begin
            byte_count_in = '0;
            header_in     = 1'b0;
            fresh_in      = 1'b1;
         end else begin
            if (byte_count_ff != COUNT_MAX) begin
               byte_count_in = byte_count_ff + COUNT_W'(1);
            end
            header_in = header_now;
            fresh_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= SCAN_LIMIT_RST;
         min_size_ff   <= MIN_SIZE_RST;
         byte_count_ff <= '0;
         header_ff     <= 1'b0;
         fresh_ff      <= 1'b0;
      end else begin
         scan_limit_ff <= scan_limit_in;
         min_size_ff   <= min_size_in;
         byte_count_ff <= byte_count_in;
         header_ff     <= header_in;
         fresh_ff      <= fresh_in;
      end
   end

   kws_match u_match (
      .clock       (clock),
      .reset       (reset),
      .step_in     (step),
      .cell_hits   (cell_hits),
      .rsp_stall   (rsp_stall),
      .hold        (hold),
      .rsp_valid   (rsp_valid),
      .rsp_verdict (rsp_verdict)
   );

endmodule

// ===== sv/kws_cell.sv =====
`timescale 1ns / 1ps

module kws_cell
   import kws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic [7:0]           din,
   input  logic [WIN_IDX_W-1:0] pos,
   output logic [7:0]           dout,
   output kw_hits_type          hits
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // take din (the neighbor's byte, or the new byte in cell 0) on each accepted request
   assign byte_in = shift ? din : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign dout = byte_ff;

   // a keyword that does not reach this cell passes here
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         hits[k] = ({1'b0, pos} >= (WIN_IDX_W + 1)'(KW_LEN[k])) ||
                   (byte_ff == KW_REV[k][pos]);
      end
   end

endmodule

// ===== sv/kws_match.sv =====
`timescale 1ns / 1ps

module kws_match
   import kws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  kws_step_type         step_in,
   input  kw_hits_type          cell_hits [WINDOW_BYTES],
   input  logic                 rsp_stall,
   output logic                 hold,
   output logic                 rsp_valid,
   output logic [VERDICT_W-1:0] rsp_verdict
);

   kws_step_type             step_ff;
   kws_step_type             step_in_sel;
   logic [GROUP_COUNT-1:0]   group_ff;
   logic [GROUP_COUNT-1:0]   group_in;
   logic [GROUP_COUNT-1:0]   group_hits;
   logic [GROUP_COUNT-1:0]   group_next;
   kw_hits_type              kw_hit;
   logic [VERDICT_W-1:0]     verdict;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [VERDICT_W-1:0]     rsp_verdict_ff;
   logic [VERDICT_W-1:0]     rsp_verdict_in;
   logic                     finish;

   // hold a finished image while the previous verdict is still waiting
   assign hold   = step_ff.valid && step_ff.last && rsp_valid_ff && rsp_stall;
   assign finish = !hold && step_ff.valid && step_ff.last;

   // combine cell compares into keyword and group hits
   always_comb begin
      group_hits = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         kw_hit[k] = 1'b1;
         for (int i = 0; i < WINDOW_BYTES; i++) begin
            kw_hit[k] = kw_hit[k] & cell_hits[i][k];
         end
         if (kw_hit[k]) begin
            group_hits[KW_GROUP[k]] = 1'b1;
         end
      end
   end

   assign group_next = group_ff | (step_ff.scan ? group_hits : '0);

   // pick the lowest flagged group; unknown unless the image is large enough and has the header
   always_comb begin
      verdict = VERDICT_UNKNOWN;
      for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
         if (group_next[g]) begin
            verdict = VERDICT_W'(g + 1);
         end
      end
      if (!(step_ff.size_ok && step_ff.header)) begin
         verdict = VERDICT_UNKNOWN;
      end
   end

   // advance the step and group flags
   always_comb begin
      step_in_sel = hold ? step_ff : step_in;
      group_in    = group_ff;
      if (!hold && step_ff.valid) begin
         group_in = step_ff.last ? '0 : group_next;
      end
   end

   // load or drain the output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      if (finish) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = verdict;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         group_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in_sel;
         group_ff     <= group_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

// ===== sv/kws_checker.sv =====
`timescale 1ns / 1ps

module kws_checker
   import kws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_stall,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [VERDICT_W-1:0] rsp_verdict
);

   // a stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_verdict))
      else $error("verdict changed while stalled");

   // the request side stalls only behind a stalled verdict
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a pending verdict");

   // reset empties the output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict valid after reset");

   // a verdict names one of the six groups or unknown
   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict <= VERDICT_W'(GROUP_COUNT))
      else $error("verdict code out of range");

endmodule

bind keyword_signature_classifier kws_checker u_kws_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_verdict (rsp_verdict)
);
